/* src/max_interval_overlap_point_defines.svh */
// Assertion macros for the maximum interval overlap point block.
// Included by the top level; no other dependencies.
`ifndef MAX_INTERVAL_OVERLAP_POINT_DEFINES_SVH
`define MAX_INTERVAL_OVERLAP_POINT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define MXOP_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// When the condition holds, the consequence must hold in the following cycle.
`define MXOP_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`else
`define MXOP_ASSERT_ALWAYS(label, clk, rst, prop)
`define MXOP_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif
`endif

/* src/mxop_pkg.sv */
// Package for the maximum interval overlap point block: item types,
// sequencer states and the control group for the cover unit. No dependencies.
package mxop_pkg;

   localparam int TIME_BITS  = 16;
   localparam int COUNT_BITS = 9;

   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] end_time;
      logic                 last;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]  best_time;
      logic [COUNT_BITS-1:0] best_count;
      logic                  found;
      logic                  overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_OUTER,
      ST_LATCH,
      ST_INNER,
      ST_DRAIN,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_s;      // capture the candidate start time, clear the count
      logic cmp_en;      // compare one stored interval against the candidate
      logic update;      // fold the finished count into the best result
      logic clear_best;  // forget the best result of the previous set
   } cover_ctl_type;

endpackage

/* src/mxop_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mxop_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mxop_cover_unit.sv */
// Shared compare-and-count unit: counts intervals covering a candidate
// start time and keeps the best candidate. Depends on mxop_pkg.
module mxop_cover_unit
   import mxop_pkg::*;
#(
   parameter int CNT_W = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cover_ctl_type        ctl,
   input  logic [TIME_BITS-1:0] rd_start,
   input  logic [TIME_BITS-1:0] rd_end,
   output logic [TIME_BITS-1:0] best_time,
   output logic [CNT_W-1:0]     best_count
);

   logic [TIME_BITS-1:0] s_ff, s_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] best_t_ff, best_t_in;
   logic [CNT_W-1:0]     best_c_ff, best_c_in;
   logic                 covers;
   logic                 better;

   assign covers = (rd_start <= s_ff) && (rd_end >= s_ff);
   assign better = (cnt_ff != '0) &&
                   ((cnt_ff > best_c_ff) || ((cnt_ff == best_c_ff) && (s_ff < best_t_ff)));

   always_comb begin
      s_in      = s_ff;
      cnt_in    = cnt_ff;
      best_t_in = best_t_ff;
      best_c_in = best_c_ff;
      if (ctl.load_s) begin
         s_in   = rd_start;
         cnt_in = '0;
      end else if (ctl.cmp_en && covers) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (ctl.clear_best) begin
         best_t_in = '0;
         best_c_in = '0;
      end else if (ctl.update && better) begin
         best_t_in = s_ff;
         best_c_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         best_t_ff <= '0;
         best_c_ff <= '0;
      end else begin
         best_t_ff <= best_t_in;
         best_c_ff <= best_c_in;
      end
   end

   assign best_time  = best_t_ff;
   assign best_count = best_c_ff;

endmodule

/* src/max_interval_overlap_point.sv */
// Top level of the maximum interval overlap point block: load sequencer,
// scan sequencer and result register. Depends on mxop_pkg, mxop_ram,
// mxop_cover_unit and max_interval_overlap_point_defines.svh.
//
//   Channel  Direction  Ports                          Carries
//   req      in         req_valid/req_ready/req_data   one interval, last marks end of set
//   rsp      out        rsp_valid/rsp_ready/rsp_data   best time, count, found, overflow
//
// Loading accepts one item per cycle. The item marked last starts a scan of the n stored
// intervals: each candidate start time costs one read of the start memory and a capture,
// then n reads through the one read port into the cover unit, a drain step and an update.
// The DONE state then hands the result over; it waits while the previous result still
// sits in the output register. Reset is synchronous and clears the sequencer, counters,
// flags, output valid and best result. Input is accepted only while loading.
`include "max_interval_overlap_point_defines.svh"
module max_interval_overlap_point
   import mxop_pkg::*;
#(
   parameter int MAX_ITEMS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [ADDR_W-1:0]    i_ff, i_in;
   logic [ADDR_W-1:0]    k_ff, k_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 store_en;
   logic                 finish;
   logic [CNT_W-1:0]     count_m1;
   logic [ADDR_W-1:0]    last_idx;
   logic [ADDR_W-1:0]    rd_addr;
   logic [TIME_BITS-1:0] rd_start;
   logic [TIME_BITS-1:0] rd_end;
   logic [TIME_BITS-1:0] best_time;
   logic [CNT_W-1:0]     best_count;
   logic                 rsp_blank;
   cover_ctl_type        ctl;

   // An item is stored only while there is room; otherwise it only raises overflow.
   assign accept   = req_valid && req_ready;
   assign store_en = accept && (count_ff != MAX_CNT);
   assign count_m1 = count_ff - 1'b1;
   assign last_idx = count_m1[ADDR_W-1:0];
   // The result is handed over once the output register is free.
   assign finish   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   mxop_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_ITEMS)
   ) u_start_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.start_time),
      .rd_addr (rd_addr),
      .rd_data (rd_start)
   );

   mxop_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (MAX_ITEMS)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.end_time),
      .rd_addr (rd_addr),
      .rd_data (rd_end)
   );

   mxop_cover_unit #(
      .CNT_W (CNT_W)
   ) u_cover (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rd_start   (rd_start),
      .rd_end     (rd_end),
      .best_time  (best_time),
      .best_count (best_count)
   );

   // Next state. Each candidate i goes OUTER (read start i), LATCH (capture it),
   // INNER (read every interval k), DRAIN (last compare) and UPDATE (fold count).
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_data.last) begin
               state_in = ST_OUTER;
            end
         end
         ST_OUTER: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            state_in = ST_INNER;
         end
         ST_INNER: begin
            if (k_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (i_ff == last_idx) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_OUTER;
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Outputs of the sequencer: read address, cover unit control, handshake.
   always_comb begin
      req_ready      = (state_ff == ST_LOAD);
      rd_addr        = (state_ff == ST_OUTER) ? i_ff : k_ff;
      ctl.load_s     = (state_ff == ST_LATCH);
      ctl.cmp_en     = cmp_vld_ff;
      ctl.update     = (state_ff == ST_UPDATE);
      ctl.clear_best = (state_ff == ST_LOAD);
      cmp_vld_in     = (state_ff == ST_INNER);
   end

   // Counters, flags and the result register.
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (store_en) begin
         count_in = count_ff + 1'b1;
      end
      if (accept && !store_en) begin
         ovf_in = 1'b1;
      end

      if (state_ff == ST_LOAD) begin
         i_in = '0;
      end else if ((state_ff == ST_UPDATE) && (i_ff != last_idx)) begin
         i_in = i_ff + 1'b1;
      end

      if (state_ff == ST_LATCH) begin
         k_in = '0;
      end else if (state_ff == ST_INNER) begin
         k_in = k_ff + 1'b1;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in       = 1'b1;
         rsp_in.best_time   = best_time;
         rsp_in.best_count  = COUNT_BITS'(best_count);
         rsp_in.found       = (best_count != '0);
         rsp_in.overflow    = ovf_ff;
         count_in           = '0;
         ovf_in             = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Both reported values of the held result are zero.
   assign rsp_blank = (rsp_ff.best_count == '0) && (rsp_ff.best_time == '0);

   // The store never holds more intervals than it has room for.
   `MXOP_ASSERT_ALWAYS(a_count_max, clock, reset, count_ff <= MAX_CNT)
   // During a scan the candidate index stays inside the stored set.
   `MXOP_ASSERT_ALWAYS(a_idx_range, clock, reset, (state_ff == ST_LOAD) || (i_ff <= last_idx))
   // A final item starts the scan on the next cycle.
   `MXOP_ASSERT_NEXT(a_last_scan, clock, reset, accept && req_data.last, state_ff == ST_OUTER)
   // A result without a covered point reports zero time and zero count.
   `MXOP_ASSERT_ALWAYS(a_not_found, clock, reset, !rsp_valid_ff || rsp_ff.found || rsp_blank)

endmodule
